[hw/rtl/alpi_pkg.sv]
// shared types, constants and the cordic arctangent table for the arc/line pose interpolator
// no dependencies
package alpi_pkg;

  localparam int MAX_POSES_DEF = 64;
  localparam int CORDIC_ITERS  = 24;
  localparam logic [30:0] STEP_RESET = 31'd6554;
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

  typedef enum logic [1:0] {DIV_LEN, DIV_ANG, DIV_TURN} div_sel_t;
  typedef enum logic [1:0] {ANG_D, ANG_REM, ANG_HEAD} ang_sel_t;
  typedef enum logic [2:0] {
    MUL_STEP_TPR, MUL_LEN_SN, MUL_LEN_OMC, MUL_A_C, MUL_BS_SN, MUL_A_SN, MUL_BS_C
  } mul_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic     div_take;
    logic     set_inf;
    logic     set_dmax;
    logic     cor_go;
    ang_sel_t cor_sel;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     wr_a;
    logic     wr_b;
    logic     set_line_ab;
    logic     upd_x;
    logic     upd_y;
    logic     turn;
    logic     last;
    logic     emit;
    logic     fwd;
  } alpi_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cor_busy;
    logic straight;
    logic step_zero;
    logic len_zero;
    logic d_zero;
  } alpi_stat_t;

  function automatic logic [30:0] atan_at(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd536870912;
      5'd1:  v = 31'd316933406;
      5'd2:  v = 31'd167458907;
      5'd3:  v = 31'd85004756;
      5'd4:  v = 31'd42667331;
      5'd5:  v = 31'd21354465;
      5'd6:  v = 31'd10679838;
      5'd7:  v = 31'd5340245;
      5'd8:  v = 31'd2670163;
      5'd9:  v = 31'd1335087;
      5'd10: v = 31'd667544;
      5'd11: v = 31'd333772;
      5'd12: v = 31'd166886;
      5'd13: v = 31'd83443;
      5'd14: v = 31'd41722;
      5'd15: v = 31'd20861;
      5'd16: v = 31'd10430;
      5'd17: v = 31'd5215;
      5'd18: v = 31'd2608;
      5'd19: v = 31'd1304;
      5'd20: v = 31'd652;
      5'd21: v = 31'd326;
      5'd22: v = 31'd163;
      5'd23: v = 31'd81;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/alpi_div.sv]
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// depends on nothing
module alpi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [31:0] rem
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] dq_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r, dq_r[63]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd63;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= 32'(trial - {1'b0, dvs_r});
        dq_r  <= {dq_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        dq_r  <= {dq_r[62:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/alpi_cordic.sv]
// iterative rotation cordic: sine and cosine in q2.30 of a 32-bit binary angle
// depends on alpi_pkg
module alpi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import alpi_pkg::*;

  logic               busy_r;
  logic [4:0]         i_r;
  logic [1:0]         q_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [32:0] z_r;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] at;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({2'b00, atan_at(i_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      i_r    <= '0;
    end else if (busy_r) begin
      if (i_r == 5'(CORDIC_ITERS - 1)) busy_r <= 1'b0;
      i_r <= i_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= CORDIC_START;
      y_r <= '0;
      z_r <= $signed({3'b000, angle[29:0]});
      q_r <= angle[31:30];
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (q_r)
      2'd0: begin cos_o = x_r;  sin_o = y_r;  end
      2'd1: begin cos_o = -y_r; sin_o = x_r;  end
      2'd2: begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r; sin_o = -x_r; end
    endcase
  end

  assign busy = busy_r;

endmodule

[hw/rtl/alpi_dpath.sv]
// datapath: pose registers, step register, shared multiplier and accumulator, divider, cordic
// depends on alpi_pkg, alpi_div, alpi_cordic
module alpi_dpath #(
  parameter int MAX_POSES = alpi_pkg::MAX_POSES_DEF,
  localparam int CW = $clog2(MAX_POSES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alpi_pkg::alpi_cmd_t cmd,
  output alpi_pkg::alpi_stat_t st,
  output logic [CW-1:0]       n_o,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_data,
  input  logic signed [31:0]  in_start_x,
  input  logic signed [31:0]  in_start_y,
  input  logic [15:0]         in_start_heading,
  input  logic [30:0]         in_seg_length,
  input  logic [14:0]         in_turn_angle,
  input  logic signed [1:0]   in_steer_dir,
  output logic                out_valid,
  output logic signed [31:0]  out_pose_x,
  output logic signed [31:0]  out_pose_y,
  output logic [15:0]         out_pose_heading,
  output logic                out_forward_mark,
  output logic                out_steps_clipped,
  output logic                out_last_pose
);
  import alpi_pkg::*;

  localparam logic [CW-1:0] NMAX = CW'(MAX_POSES - 2);

  logic [30:0]        step_r;
  logic signed [31:0] x_r, y_r;
  logic [31:0]        h_r;
  logic [30:0]        len_r, turn_r;
  logic               s_pos_r, s_neg_r;
  logic [31:0]        d_r, rem_r;
  logic [CW-1:0]      n_r;
  logic               clip_r;
  logic signed [33:0] a_r, bs_r;
  logic signed [67:0] prod_r;
  logic signed [68:0] acc_r;
  logic signed [33:0] opa, opb;
  logic               out_valid_r;
  logic signed [31:0] ox_r, oy_r;
  logic [15:0]        oh_r;
  logic               ofwd_r, oclip_r, olast_r;

  logic [63:0]        div_dvd;
  logic [31:0]        div_dvs;
  logic               div_busy;
  logic [63:0]        quot;
  logic [31:0]        drem;
  div_sel_t           div_sel_r;
  logic [31:0]        cor_ang;
  logic               cor_busy;
  logic signed [33:0] cs, sn;
  logic signed [38:0] rnd_prod, rnd_acc;
  logic signed [39:0] x_diff, y_diff;
  logic [31:0]        turn_ang;
  logic [31:0]        h_half;
  logic               q_clip;

  function automatic logic signed [38:0] rnd30(input logic signed [68:0] v);
    logic signed [68:0] t;
    t = (v + 69'sd536870912) >>> 30;
    return t[38:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_STEP_TPR: begin opa = $signed({3'b0, step_r}); opb = $signed({4'b0, TURN_PER_RAD}); end
      MUL_LEN_SN:   begin opa = $signed({3'b0, len_r});  opb = sn;            end
      MUL_LEN_OMC:  begin opa = $signed({3'b0, len_r});  opb = Q30_ONE - cs;  end
      MUL_A_C:      begin opa = a_r;  opb = cs; end
      MUL_BS_SN:    begin opa = bs_r; opb = sn; end
      MUL_A_SN:     begin opa = a_r;  opb = sn; end
      MUL_BS_C:     begin opa = bs_r; opb = cs; end
      default:      begin opa = '0;   opb = '0; end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_LEN: begin div_dvd = {33'b0, len_r}; div_dvs = {1'b0, step_r}; end
      DIV_ANG: begin
        div_dvd = prod_r[63:0] + {34'b0, len_r[30:1]};
        div_dvs = {1'b0, len_r};
      end
      DIV_TURN: begin div_dvd = {33'b0, turn_r}; div_dvs = d_r; end
      default:  begin div_dvd = '0; div_dvs = '0; end
    endcase
  end

  always_comb begin
    case (cmd.cor_sel)
      ANG_D:    cor_ang = d_r;
      ANG_REM:  cor_ang = rem_r;
      ANG_HEAD: cor_ang = h_r;
      default:  cor_ang = h_r;
    endcase
  end

  alpi_div u_div (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .dividend(div_dvd), .divisor(div_dvs),
    .busy(div_busy), .quot(quot), .rem(drem)
  );

  alpi_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cmd.cor_go), .angle(cor_ang),
    .busy(cor_busy), .cos_o(cs), .sin_o(sn)
  );

  assign rnd_prod = rnd30(69'(prod_r));
  assign rnd_acc  = rnd30(acc_r);
  assign x_diff   = 40'(x_r) - 40'(rnd_acc);
  assign y_diff   = 40'(y_r) - 40'(rnd_acc);
  assign turn_ang = cmd.last ? rem_r : d_r;
  assign h_half   = h_r + 32'h0000_8000;
  assign q_clip   = quot > 64'(MAX_POSES - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= STEP_RESET;
    else if (cfg_we) step_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= 69'(prod_r);
      ACC_ADD:  acc_r <= acc_r + 69'(prod_r);
      ACC_SUB:  acc_r <= acc_r - 69'(prod_r);
      default:  acc_r <= acc_r;
    endcase
    if (cmd.div_go) div_sel_r <= cmd.div_sel;
    if (cmd.load) begin
      x_r     <= in_start_x;
      y_r     <= in_start_y;
      h_r     <= {in_start_heading, 16'b0};
      len_r   <= in_seg_length;
      turn_r  <= {in_turn_angle, 16'b0};
      s_neg_r <= in_steer_dir[1];
      s_pos_r <= (in_steer_dir == 2'sd1);
    end
    if (cmd.div_take) begin
      if (div_sel_r == DIV_ANG) begin
        d_r <= (quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : quot[31:0];
      end else begin
        rem_r  <= drem;
        clip_r <= q_clip;
        n_r    <= q_clip ? NMAX : quot[CW-1:0];
      end
    end
    if (cmd.set_inf) begin
      clip_r <= 1'b1;
      n_r    <= NMAX;
      rem_r  <= (!s_pos_r && !s_neg_r) ? {1'b0, len_r} : {1'b0, turn_r};
    end
    if (cmd.set_dmax) d_r <= 32'hFFFF_FFFF;
    if (cmd.wr_a) a_r <= rnd_prod[33:0];
    if (cmd.wr_b) begin
      if (s_neg_r)      bs_r <= -rnd_prod[33:0];
      else if (s_pos_r) bs_r <= rnd_prod[33:0];
      else              bs_r <= '0;
    end
    if (cmd.set_line_ab) begin
      a_r  <= cmd.last ? $signed({2'b0, rem_r}) : $signed({3'b0, step_r});
      bs_r <= '0;
    end
    if (cmd.upd_x) x_r <= sat32(x_diff);
    if (cmd.upd_y) y_r <= sat32(y_diff);
    if (cmd.turn) begin
      if (s_pos_r)      h_r <= h_r - turn_ang;
      else if (s_neg_r) h_r <= h_r + turn_ang;
    end
    if (cmd.emit) begin
      ox_r    <= x_r;
      oy_r    <= y_r;
      oh_r    <= h_half[31:16];
      ofwd_r  <= cmd.fwd;
      oclip_r <= clip_r;
      olast_r <= cmd.last & ~cmd.fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.emit;
  end

  assign st.div_busy  = div_busy;
  assign st.cor_busy  = cor_busy;
  assign st.straight  = !s_pos_r && !s_neg_r;
  assign st.step_zero = step_r == 31'd0;
  assign st.len_zero  = len_r == 31'd0;
  assign st.d_zero    = d_r == 32'd0;
  assign n_o          = n_r;

  assign out_valid         = out_valid_r;
  assign out_pose_x        = ox_r;
  assign out_pose_y        = oy_r;
  assign out_pose_heading  = oh_r;
  assign out_forward_mark  = ofwd_r;
  assign out_steps_clipped = oclip_r;
  assign out_last_pose     = olast_r;

endmodule

[hw/rtl/alpi_ctrl.sv]
// controller state machine: sequences divisions, cordic runs and multiply steps per pose
// depends on alpi_pkg
module alpi_ctrl #(
  parameter int MAX_POSES = alpi_pkg::MAX_POSES_DEF,
  localparam int CW = $clog2(MAX_POSES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  alpi_pkg::alpi_stat_t st,
  input  logic [CW-1:0]        n_i,
  output alpi_pkg::alpi_cmd_t  cmd
);
  import alpi_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_ADIV, ST_WDIV_N, ST_WDIV_D, ST_TDIV, ST_WDIV_T,
    ST_ARC, ST_WCOR_T, ST_T1, ST_T2, ST_T3, ST_LINE, ST_FIRST,
    ST_MOVE, ST_WCOR_M, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.last  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          last_nxt  = 1'b0;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (st.straight) begin
          if (st.step_zero) begin
            cmd.set_inf = 1'b1;
            state_nxt   = ST_LINE;
          end else begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_LEN;
            state_nxt   = ST_WDIV_N;
          end
        end else if (st.len_zero) begin
          cmd.set_dmax = 1'b1;
          state_nxt    = ST_TDIV;
        end else begin
          cmd.mul_sel = MUL_STEP_TPR;
          state_nxt   = ST_ADIV;
        end
      end
      ST_ADIV: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_ANG;
        state_nxt   = ST_WDIV_D;
      end
      ST_WDIV_N: begin
        if (!st.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_LINE;
        end
      end
      ST_WDIV_D: begin
        if (!st.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (st.d_zero) begin
          cmd.set_inf = 1'b1;
          state_nxt   = ST_ARC;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_TURN;
          state_nxt   = ST_WDIV_T;
        end
      end
      ST_WDIV_T: begin
        if (!st.div_busy) begin
          cmd.div_take = 1'b1;
          state_nxt    = ST_ARC;
        end
      end
      ST_ARC: begin
        cmd.cor_go  = 1'b1;
        cmd.cor_sel = last_r ? ANG_REM : ANG_D;
        state_nxt   = ST_WCOR_T;
      end
      ST_WCOR_T: if (!st.cor_busy) state_nxt = ST_T1;
      ST_T1: begin
        cmd.mul_sel = MUL_LEN_SN;
        state_nxt   = ST_T2;
      end
      ST_T2: begin
        cmd.wr_a    = 1'b1;
        cmd.mul_sel = MUL_LEN_OMC;
        state_nxt   = ST_T3;
      end
      ST_T3: begin
        cmd.wr_b  = 1'b1;
        state_nxt = last_r ? ST_MOVE : ST_FIRST;
      end
      ST_LINE: begin
        cmd.set_line_ab = 1'b1;
        state_nxt       = last_r ? ST_MOVE : ST_FIRST;
      end
      ST_FIRST: begin
        cmd.emit = 1'b1;
        cmd.fwd  = 1'b1;
        cnt_nxt  = n_i;
        if (n_i == '0) begin
          last_nxt  = 1'b1;
          state_nxt = st.straight ? ST_LINE : ST_ARC;
        end else begin
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd.cor_go  = 1'b1;
        cmd.cor_sel = ANG_HEAD;
        state_nxt   = ST_WCOR_M;
      end
      ST_WCOR_M: if (!st.cor_busy) state_nxt = ST_M1;
      ST_M1: begin
        cmd.mul_sel = MUL_A_C;
        state_nxt   = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = MUL_BS_SN;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_M3;
      end
      ST_M3: begin
        cmd.mul_sel = MUL_A_SN;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = ST_M4;
      end
      ST_M4: begin
        cmd.mul_sel = MUL_BS_C;
        cmd.acc_op  = ACC_LOAD;
        cmd.upd_x   = 1'b1;
        state_nxt   = ST_M5;
      end
      ST_M5: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = ST_M6;
      end
      ST_M6: begin
        cmd.upd_y = 1'b1;
        cmd.turn  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (last_r) begin
          last_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else if (cnt_r == CW'(1)) begin
          cnt_nxt   = '0;
          last_nxt  = 1'b1;
          state_nxt = st.straight ? ST_LINE : ST_ARC;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_MOVE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule

[hw/rtl/arc_line_pose_interpolator_core.sv]
// arc/line pose interpolator top: one start pose in, a run of n + 2 backward-stepped poses out
// sequence: set-up (divisions, and for an arc its chord terms) before the first pose, then per
// pose a cordic start, the cordic wait, six multiply/accumulate steps and the emit; an arc's
// last pose first computes its own chord terms
// throughput: one item at a time, start is taken only while busy is low
// each pose word is strobed by out_valid for one cycle; the receiver cannot stall
// reset: synchronous active-low rst_n returns to idle and loads step_length with its default
module arc_line_pose_interpolator_core #(
  parameter int MAX_POSES = alpi_pkg::MAX_POSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic [15:0]        in_start_heading,
  input  logic [30:0]        in_seg_length,
  input  logic [14:0]        in_turn_angle,
  input  logic signed [1:0]  in_steer_dir,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic [15:0]        out_pose_heading,
  output logic               out_forward_mark,
  output logic               out_steps_clipped,
  output logic               out_last_pose
);
  import alpi_pkg::*;

  localparam int CW = $clog2(MAX_POSES);

  // command and status between sequencer and datapath
  alpi_cmd_t     cmd;
  alpi_stat_t    st;
  logic [CW-1:0] n_steps;

  // sequencer: set-up divisions, then per pose a cordic run and the multiply steps
  alpi_ctrl #(.MAX_POSES(MAX_POSES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .st(st), .n_i(n_steps), .cmd(cmd)
  );

  // datapath: step register, pose registers, divider, cordic, shared multiplier
  alpi_dpath #(.MAX_POSES(MAX_POSES)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .n_o(n_steps),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_start_heading(in_start_heading), .in_seg_length(in_seg_length),
    .in_turn_angle(in_turn_angle), .in_steer_dir(in_steer_dir),
    .out_valid(out_valid), .out_pose_x(out_pose_x), .out_pose_y(out_pose_y),
    .out_pose_heading(out_pose_heading), .out_forward_mark(out_forward_mark),
    .out_steps_clipped(out_steps_clipped), .out_last_pose(out_last_pose)
  );

  // a word only ever follows a cycle in which the sequencer was working
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("pose word without an active run");

  // an accepted start always begins a run
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("start not taken");

  // the first pose is never the last one
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_forward_mark && out_last_pose))
    else $error("forward pose flagged last");

  // after the first pose the next word is a pose computation away
  a_first_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_forward_mark) |=> !out_valid)
    else $error("back-to-back words after the first pose");

endmodule

[sim/arc_line_pose_interpolator_core_tb.sv]
// self-checking testbench for arc_line_pose_interpolator_core: directed and random start poses
// depends on alpi_pkg and the core rtl; poses are predicted in-bench and checked word by word
`timescale 1ns / 100ps

module arc_line_pose_interpolator_core_tb;
  import alpi_pkg::*;

  localparam int         RUN_POSES  = 64;
  localparam int         CYCLE_CAP  = 6000000;
  localparam longint     SIN_START  = 652032874;
  localparam longint     UNIT_Q30   = 1073741824;
  localparam longint     TURN_RAD   = 683565276;
  localparam logic [1:0] STEER_STR  = 2'b00;
  localparam logic [1:0] STEER_LEFT = 2'b01;
  localparam logic [1:0] STEER_RGT  = 2'b11;
  localparam logic [1:0] STEER_RGT2 = 2'b10;

  // one pose word as it leaves the core
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        hd;
    logic               fwd;
    logic               clip;
    logic               last;
  } pose_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic [15:0]        in_start_heading = '0;
  logic [30:0]        in_seg_length = '0;
  logic [14:0]        in_turn_angle = '0;
  logic signed [1:0]  in_steer_dir = '0;
  logic               cfg_we = 1'b0;
  logic [30:0]        cfg_data = '0;
  logic               out_valid;
  logic signed [31:0] out_pose_x;
  logic signed [31:0] out_pose_y;
  logic [15:0]        out_pose_heading;
  logic               out_forward_mark;
  logic               out_steps_clipped;
  logic               out_last_pose;

  pose_t       exp_poses[$];
  int          n_errors = 0;
  int          cyc = 0;
  logic [30:0] step_shadow = STEP_RESET;

  // arctangent table of the rotation steps, 2^32 = full turn
  longint atan_steps[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  always #5 clk = ~clk;

  arc_line_pose_interpolator_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_start_heading(in_start_heading), .in_seg_length(in_seg_length),
    .in_turn_angle(in_turn_angle), .in_steer_dir(in_steer_dir),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_pose_x(out_pose_x), .out_pose_y(out_pose_y),
    .out_pose_heading(out_pose_heading), .out_forward_mark(out_forward_mark),
    .out_steps_clipped(out_steps_clipped), .out_last_pose(out_last_pose)
  );

  // ---------------------------------------------------------------- predictor

  // round half up then floor shift; >>> on a signed longint already floors
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // 24 rotations on the low angle bits, then the quadrant fold, results in q2.30
  task automatic sin_cos_q30(input logic [31:0] ang, output longint co, output longint si);
    longint x, y, z, xs, ys;
    x = SIN_START;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_steps[i];
      end else begin
        x += ys; y -= xs; z += atan_steps[i];
      end
    end
    case (ang[31:30])
      2'd0:    begin co = x;  si = y;  end
      2'd1:    begin co = -y; si = x;  end
      2'd2:    begin co = -x; si = -y; end
      default: begin co = y;  si = -x; end
    endcase
  endtask

  // step back along heading h by chord terms a (along) and b (sideways)
  task automatic step_back(inout longint x, inout longint y, input logic [31:0] h,
                           input longint a, input longint b, input int s);
    longint c, sn;
    sin_cos_q30(h, c, sn);
    x = clamp32(x - rnd_shift(a * c + longint'(s) * b * sn, 30));
    y = clamp32(y - rnd_shift(a * sn - longint'(s) * b * c, 30));
  endtask

  task automatic chord_terms(input longint r, input logic [31:0] ang,
                             output longint a, output longint b);
    longint c, sn;
    sin_cos_q30(ang, c, sn);
    a = rnd_shift(r * sn, 30);
    b = rnd_shift(r * (UNIT_Q30 - c), 30);
  endtask

  function automatic void queue_pose(longint x, longint y, logic [31:0] h,
                                     logic f, logic c, logic l);
    pose_t p;
    logic [31:0] hr;
    hr = h + 32'h8000;
    p.px = x[31:0]; p.py = y[31:0]; p.hd = hr[31:16];
    p.fwd = f; p.clip = c; p.last = l;
    exp_poses.insert(exp_poses.size(), p);
  endfunction

  // expected pose run for one accepted start word
  task automatic predict_run(input logic signed [31:0] sx, input logic signed [31:0] sy,
                             input logic [15:0] hd, input logic [30:0] len,
                             input logic [14:0] turn, input logic [1:0] steer);
    longint x, y, a, b;
    longint unsigned step, l, t, n, rem, d;
    logic [31:0] h;
    logic inf, clip;
    int s;
    x = sx; y = sy; h = {hd, 16'h0};
    l = len; t = longint'(turn) << 16; step = step_shadow;
    s = steer[1] ? -1 : (steer[0] ? 1 : 0);
    n = 0; d = 0; inf = 1'b0;
    if (s == 0) begin
      if (step == 0) begin inf = 1'b1; rem = l; end
      else begin n = l / step; rem = l % step; end
    end else begin
      if (l == 0) d = 64'hFFFF_FFFF;
      else begin
        d = (step * TURN_RAD + l / 2) / l;
        if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      end
      if (d == 0) begin inf = 1'b1; rem = t; end
      else begin n = t / d; rem = t % d; end
    end
    clip = inf || n > RUN_POSES - 2;
    if (clip) n = RUN_POSES - 2;
    queue_pose(x, y, h, 1'b1, clip, 1'b0);
    if (s == 0) begin
      for (longint unsigned i = 0; i < n; i++) begin
        step_back(x, y, h, longint'(step), 0, 0);
        queue_pose(x, y, h, 1'b0, clip, 1'b0);
      end
      step_back(x, y, h, longint'(rem), 0, 0);
    end else begin
      chord_terms(longint'(l), d[31:0], a, b);
      for (longint unsigned i = 0; i < n; i++) begin
        step_back(x, y, h, a, b, s);
        h = (s > 0) ? h - d[31:0] : h + d[31:0];
        queue_pose(x, y, h, 1'b0, clip, 1'b0);
      end
      chord_terms(longint'(l), rem[31:0], a, b);
      step_back(x, y, h, a, b, s);
      h = (s > 0) ? h - rem[31:0] : h + rem[31:0];
    end
    queue_pose(x, y, h, 1'b0, clip, 1'b1);
  endtask

  // ---------------------------------------------------------------- checking

  // outputs are stable mid-cycle, so each strobed word is taken at the falling edge
  always @(negedge clk) begin
    pose_t e;
    if (rst_n && out_valid) begin
      if (exp_poses.size() == 0) begin
        $error("pose word with nothing expected");
        n_errors++;
      end else begin
        e = exp_poses.pop_front();
        if (out_pose_x !== e.px) begin
          $error("pose_x exp %0d got %0d", e.px, out_pose_x); n_errors++;
        end
        if (out_pose_y !== e.py) begin
          $error("pose_y exp %0d got %0d", e.py, out_pose_y); n_errors++;
        end
        if (out_pose_heading !== e.hd) begin
          $error("pose_heading exp %0d got %0d", e.hd, out_pose_heading); n_errors++;
        end
        if (out_forward_mark !== e.fwd) begin
          $error("forward_mark exp %0d got %0d", e.fwd, out_forward_mark); n_errors++;
        end
        if (out_steps_clipped !== e.clip) begin
          $error("steps_clipped exp %0d got %0d", e.clip, out_steps_clipped); n_errors++;
        end
        if (out_last_pose !== e.last) begin
          $error("last_pose exp %0d got %0d", e.last, out_last_pose); n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // present one start word and hold it until the core takes it; start is left high
  task automatic send_word(input logic signed [31:0] sx, input logic signed [31:0] sy,
                           input logic [15:0] hd, input logic [30:0] len,
                           input logic [14:0] turn, input logic [1:0] steer);
    logic taken;
    in_start_x <= sx; in_start_y <= sy; in_start_heading <= hd;
    in_seg_length <= len; in_turn_angle <= turn; in_steer_dir <= steer;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    predict_run(sx, sy, hd, len, turn, steer);
  endtask

  task automatic maybe_gap(input bit allow);
    if (allow && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // wait for every pose to come back, then the core's tail
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (exp_poses.size() != 0 || busy);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_step(input logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_shadow = v;
  endtask

  // random start word; lengths lean towards a few dozen steps so runs stay varied
  task automatic send_random(input bit allow_gap);
    logic [30:0] len;
    logic [1:0]  steer;
    longint unsigned span;
    span = longint'(step_shadow) * 70 + 1;
    if (span > 31'h7FFF_FFFF) span = 31'h7FFF_FFFF;
    case ($urandom_range(0, 3))
      0:       len = 31'($urandom);
      1:       len = 31'($urandom_range(0, 255));
      default: len = 31'($urandom_range(0, int'(span)));
    endcase
    case ($urandom_range(0, 3))
      0:       steer = STEER_STR;
      1:       steer = STEER_LEFT;
      2:       steer = STEER_RGT;
      default: steer = STEER_RGT2;
    endcase
    send_word($urandom, $urandom, 16'($urandom), len, 15'($urandom), steer);
    maybe_gap(allow_gap);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // default step of 0.1 m
    send_word(0, 0, 16'h0000, 31'd65536, 15'd0, STEER_STR);
    send_word(32'sh7FFF_0000, -32'sh7FFF_0000, 16'h8000, 31'd200000, 15'd0, STEER_STR);
    send_word(32'sh7FFF_FFF0, 0, 16'h8000, 31'h7FFF_FFFF, 15'd0, STEER_STR);  // clip, saturate
    send_word(-32'sh7FFF_FFF0, 5, 16'h0000, 31'd6553, 15'd0, STEER_STR);     // shorter than a step
    send_word(100, 200, 16'hFFFF, 31'd0, 15'd0, STEER_STR);                   // zero length
    send_word(0, 0, 16'h4000, 31'd655360, 15'd4096, STEER_LEFT);
    send_word(0, 0, 16'hC000, 31'd655360, 15'd16384, STEER_RGT);
    send_word(1, -1, 16'h1234, 31'd131072, 15'h7FFF, STEER_RGT2);            // minus two code
    send_word(0, 0, 16'h0100, 31'd1, 15'd8192, STEER_LEFT);                  // tiny radius
    send_word(0, 0, 16'hFF00, 31'd0, 15'd16384, STEER_RGT);                  // zero radius
    send_word(0, 0, 16'h0000, 31'h7FFF_FFFF, 15'd1, STEER_LEFT);             // largest radius
    send_word(-32'sh8000_0000, 32'sh7FFF_FFFF, 16'h6000, 31'h7FFF_FFFF, 15'h7FFF, STEER_LEFT);
    drain();
  endtask

  task automatic test_zero_step();
    write_step(31'd0);
    send_word(0, 0, 16'h2000, 31'd100000, 15'd0, STEER_STR);
    send_word(7, 9, 16'h2000, 31'd100000, 15'd5000, STEER_LEFT);
    send_word(7, 9, 16'hA000, 31'd0, 15'd5000, STEER_RGT);
    drain();
  endtask

  task automatic test_max_step();
    write_step(31'h7FFF_FFFF);
    send_word(0, 0, 16'h0000, 31'h7FFF_FFFF, 15'd0, STEER_STR);
    send_word(0, 0, 16'h3000, 31'd65536, 15'd16384, STEER_LEFT);
    send_word(-3, 3, 16'h3000, 31'h7FFF_FFFF, 15'h7FFF, STEER_RGT);
    drain();
  endtask

  task automatic test_random(input logic [30:0] step, input int count, input bit gaps);
    write_step(step);
    for (int i = 0; i < count; i++) send_random(gaps);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_step();
    test_max_step();
    test_random(STEP_RESET, 100, 1'b1);
    test_random(31'd1, 60, 1'b1);
    test_random(31'($urandom_range(1, 1 << 20)), 100, 1'b1);
    test_random(31'($urandom), 60, 1'b1);
    test_random(31'd65536, 80, 1'b0);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
